@@ rtl/dual_pump_hysteresis_controller_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dual pump controller checker.
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_PUMP_HYSTERESIS_CONTROLLER_MACROS_SVH
`define DUAL_PUMP_HYSTERESIS_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define DPHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dphc assertion failed");

// Next-cycle implication.
`define DPHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dphc assertion failed");

`endif

@@ rtl/dphc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphc_pkg
// Types and constants shared by the dual pump controller and its checker.
// ----------------------------------------------------------------------------
package dphc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_P_W    = 12;
  localparam int ELAPSED_W  = 16;
  localparam int TIME_W     = 32;

  // Input fields other than pressure: elapsed time and two clear flags.
  localparam int IN_FIXED_W = ELAPSED_W + 2;

  // Result beat: three flags and two runtime counters, padded to bytes.
  localparam int OUT_RAW_W = 3 + 2 * TIME_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int OUT_P1_BIT   = 0;
  localparam int OUT_P2_BIT   = 1;
  localparam int OUT_FILL_BIT = 2;

  typedef enum logic [2:0] {
    MODE_AUTO     = 3'd0,
    MODE_OFF      = 3'd1,
    MODE_BOTH     = 3'd2,
    MODE_ONE_ONLY = 3'd3,
    MODE_TWO_ONLY = 3'd4
  } pump_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUMP_MODE   = 3'd0,
    REG_TARGET      = 3'd1,
    REG_FILL_START  = 3'd2,
    REG_MAX         = 3'd3,
    REG_BOTH_PUMPS  = 3'd4,
    REG_SWITCH_IVAL = 3'd5
  } cfg_reg_t;

  localparam logic [CFG_P_W-1:0]    RST_TARGET      = 12'd1500;
  localparam logic [CFG_P_W-1:0]    RST_FILL_START  = 12'd1200;
  localparam logic [CFG_P_W-1:0]    RST_MAX         = 12'd1500;
  localparam logic [CFG_P_W-1:0]    RST_BOTH_PUMPS  = 12'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_SWITCH_IVAL = 22'd60000;

endpackage

@@ rtl/dual_pump_hysteresis_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pump_hysteresis_controller
// Lead/lag control of two pumps with fill hysteresis and runtime counters.
// ----------------------------------------------------------------------------
// Usage: every input beat on in_* is one tick with a pressure sample, the
// milliseconds since the previous tick and two runtime clear requests. Each
// tick yields exactly one result beat on out_* with both pump drives, the
// fill flag and the two wrapping runtime counters.
// From input beat to result beat a tick passes one input register, then the
// decision logic and the result register. A new tick is taken in every cycle
// while the receiver does not stall; the only loop is the registered update
// of the pump state, the switch timer and the runtime counters.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more tick; after that in_tready drops until out_tready
// returns. Ticks are never dropped or duplicated.
// Reset (rst_n low, synchronous) empties both registers, switches both pumps
// off, clears the fill flag, the timers and the runtimes, and loads the
// register defaults. Configuration writes on cfg_* take effect at once and
// are meant to happen only while no tick is in flight.
// ----------------------------------------------------------------------------
module dual_pump_hysteresis_controller #(
  parameter int PRESSURE_WIDTH = 12
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // pressure, elapsed_ms[15:0], clear_runtime_one, clear_runtime_two, zero pad
  input  logic [((PRESSURE_WIDTH + dphc_pkg::IN_FIXED_W + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // pump_one_on, pump_two_on, fill_active, runtime_one_ms[31:0],
  // runtime_two_ms[31:0], zero pad
  output logic [dphc_pkg::OUT_W-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [dphc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dphc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dphc_pkg::*;

  localparam int PW = PRESSURE_WIDTH;

  // Configuration registers.
  pump_mode_t             mode_r;
  logic [CFG_P_W-1:0]     target_r;
  logic [CFG_P_W-1:0]     start_r;
  logic [CFG_P_W-1:0]     max_r;
  logic [CFG_P_W-1:0]     both_r;
  logic [CFG_DATA_W-1:0]  interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_AUTO;
      target_r   <= RST_TARGET;
      start_r    <= RST_FILL_START;
      max_r      <= RST_MAX;
      both_r     <= RST_BOTH_PUMPS;
      interval_r <= RST_SWITCH_IVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PUMP_MODE:   mode_r     <= pump_mode_t'(cfg_wdata[2:0]);
        REG_TARGET:      target_r   <= cfg_wdata[CFG_P_W-1:0];
        REG_FILL_START:  start_r    <= cfg_wdata[CFG_P_W-1:0];
        REG_MAX:         max_r      <= cfg_wdata[CFG_P_W-1:0];
        REG_BOTH_PUMPS:  both_r     <= cfg_wdata[CFG_P_W-1:0];
        REG_SWITCH_IVAL: interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic in_valid_r;
  logic out_valid_r;
  logic advance;
  logic step;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step      = in_valid_r && advance;

  // Input register.
  logic [PW-1:0]        pres_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic                 clr_one_r;
  logic                 clr_two_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pres_r    <= in_tdata[PW-1:0];
      elapsed_r <= in_tdata[PW+ELAPSED_W-1:PW];
      clr_one_r <= in_tdata[PW+ELAPSED_W];
      clr_two_r <= in_tdata[PW+ELAPSED_W+1];
    end
  end

  // Controller state. The switch timer holds the time since the last
  // alternation, so only one add feeds the interval compare.
  logic              fill_r, fill_nxt;
  logic              alt_r, alt_nxt;
  logic              p1_r, p1_nxt;
  logic              p2_r, p2_nxt;
  logic [TIME_W-1:0] since_r, since_nxt;
  logic [TIME_W-1:0] rt1_r, rt1_nxt;
  logic [TIME_W-1:0] rt2_r, rt2_nxt;

  logic [TIME_W-1:0] el_ext;
  logic [TIME_W-1:0] since_sum;
  logic [TIME_W-1:0] rt1_base;
  logic [TIME_W-1:0] rt2_base;
  logic [PW-1:0]     lo_p;
  logic [PW-1:0]     hi_p;
  logic [PW-1:0]     both_p;
  logic [PW-1:0]     tgt_clip;
  logic [PW-1:0]     tgt_p;

  assign el_ext    = TIME_W'(elapsed_r);
  assign since_sum = since_r + el_ext;
  assign rt1_base  = clr_one_r ? '0 : rt1_r;
  assign rt2_base  = clr_two_r ? '0 : rt2_r;
  assign rt1_nxt   = p1_r ? rt1_base + el_ext : rt1_base;
  assign rt2_nxt   = p2_r ? rt2_base + el_ext : rt2_base;

  assign lo_p     = PW'(start_r);
  assign hi_p     = PW'(max_r);
  assign both_p   = PW'(both_r);
  assign tgt_clip = (PW'(target_r) > hi_p) ? hi_p : PW'(target_r);
  assign tgt_p    = (tgt_clip < lo_p) ? lo_p : tgt_clip;

  always_comb begin
    fill_nxt  = fill_r;
    alt_nxt   = alt_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    since_nxt = since_sum;
    case (mode_r)
      MODE_AUTO: begin
        if (pres_r >= tgt_p) begin
          fill_nxt = 1'b0;
          p1_nxt   = 1'b0;
          p2_nxt   = 1'b0;
        end else if (!fill_r && (pres_r >= lo_p)) begin
          p1_nxt = 1'b0;
          p2_nxt = 1'b0;
        end else begin
          fill_nxt = 1'b1;
          if (pres_r <= both_p) begin
            p1_nxt = 1'b1;
            p2_nxt = 1'b1;
          end else begin
            if (since_sum >= TIME_W'(interval_r)) begin
              alt_nxt   = !alt_r;
              since_nxt = '0;
            end
            p1_nxt = !alt_nxt;
            p2_nxt = alt_nxt;
          end
        end
      end
      MODE_OFF: begin
        fill_nxt = 1'b0;
        p1_nxt   = 1'b0;
        p2_nxt   = 1'b0;
      end
      MODE_BOTH: begin
        fill_nxt = 1'b0;
        p1_nxt   = 1'b1;
        p2_nxt   = 1'b1;
      end
      MODE_ONE_ONLY: begin
        fill_nxt = 1'b0;
        p1_nxt   = 1'b1;
        p2_nxt   = 1'b0;
      end
      MODE_TWO_ONLY: begin
        fill_nxt = 1'b0;
        p1_nxt   = 1'b0;
        p2_nxt   = 1'b1;
      end
      default: begin
        // Undefined mode codes hold the drives and only end a fill cycle.
        fill_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= 1'b0;
      alt_r   <= 1'b0;
      p1_r    <= 1'b0;
      p2_r    <= 1'b0;
      since_r <= '0;
      rt1_r   <= '0;
      rt2_r   <= '0;
    end else if (step) begin
      fill_r  <= fill_nxt;
      alt_r   <= alt_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      since_r <= since_nxt;
      rt1_r   <= rt1_nxt;
      rt2_r   <= rt2_nxt;
    end
  end

  // Result register.
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= OUT_W'({rt2_nxt, rt1_nxt, fill_nxt, p2_nxt, p1_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/dphc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dphc_checker
// Port-level assertions for the dual pump controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_pump_hysteresis_controller_macros.svh"

module dphc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_tvalid,
  input logic out_tready,
  input logic [dphc_pkg::OUT_W-1:0] out_tdata
);
  import dphc_pkg::*;

  logic fill_seen;
  logic any_pump;
  logic stalled;

  assign fill_seen = out_tvalid && out_tdata[OUT_FILL_BIT];
  assign any_pump  = out_tdata[OUT_P1_BIT] || out_tdata[OUT_P2_BIT];
  assign stalled   = out_tvalid && !out_tready;

  // A stalled result beat must hold until it is taken.
  `DPHC_ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(out_tdata))

  // An active fill cycle always runs at least one pump.
  `DPHC_ASSERT_NOW(a_fill_runs_pump, fill_seen, any_pump)

  // Coming out of reset the result channel is empty.
  `DPHC_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_tvalid)

endmodule

bind dual_pump_hysteresis_controller dphc_checker u_dphc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ sim/dual_pump_hysteresis_controller_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pump_hysteresis_controller_test
// Self-checking bench for the lead/lag pump controller.
// ----------------------------------------------------------------------------
// Ticks go in on the in_ stream and a predictor in this file works out the
// pump drives, the fill flag and both runtime counters for every accepted
// beat. Each result beat on the out_ stream is checked field by field against
// the oldest prediction. Directed ticks cover the thresholds, every mode and
// the target clamp; random ticks sweep the pressure through fill cycles under
// random settings, with random stalls on both stream sides but in the last pass.
// ----------------------------------------------------------------------------
module dual_pump_hysteresis_controller_test;
  import dphc_pkg::*;

  localparam int PRESSURE_W = 12;
  localparam int IN_W       = ((PRESSURE_W + IN_FIXED_W + 7) / 8) * 8;
  localparam int PIPE_LAT   = 2;
  localparam int SEG_TICKS  = 70;
  localparam int SEGMENTS   = 5;
  localparam int MAX_REPORT = 10;

  // Mode codes the block does not define; the drives must hold.
  localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
  localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

  localparam logic [21:0] IVAL_MAX = 22'd3600000;

  typedef struct {
    bit        pump_one;
    bit        pump_two;
    bit        fill;
    bit [31:0] run_one;
    bit [31:0] run_two;
  } pump_status_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Register copies for the predictor.
  logic [2:0]  mode_reg;
  logic [11:0] target_reg;
  logic [11:0] start_reg;
  logic [11:0] max_reg;
  logic [11:0] both_reg;
  logic [21:0] ival_reg;

  // Predictor state.
  bit        fill_on;
  bit        alt_sel;
  bit        drive_one;
  bit        drive_two;
  bit [31:0] clock_ms;
  bit [31:0] last_toggle_ms;
  bit [31:0] run_one_ms;
  bit [31:0] run_two_ms;

  pump_status_t pending_status[$];
  int mismatch_count = 0;
  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;

  dual_pump_hysteresis_controller #(
    .PRESSURE_WIDTH(PRESSURE_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic [11:0] effective_target();
    logic [11:0] tgt;
    tgt = target_reg;
    if (tgt > max_reg) tgt = max_reg;
    if (tgt < start_reg) tgt = start_reg;
    return tgt;
  endfunction

  // One controller tick: clock, runtime clears and accumulation, then the
  // pump decision for the current mode.
  function automatic pump_status_t advance_pumps(input logic [11:0] p,
                                                 input logic [15:0] el,
                                                 input logic clr_one,
                                                 input logic clr_two);
    pump_status_t st;
    logic [11:0]  tgt;
    bit [31:0]    since_toggle;
    clock_ms = clock_ms + el;
    if (clr_one) run_one_ms = '0;
    if (clr_two) run_two_ms = '0;
    if (drive_one) run_one_ms = run_one_ms + el;
    if (drive_two) run_two_ms = run_two_ms + el;
    if (mode_reg != MODE_AUTO) fill_on = 1'b0;
    case (mode_reg)
      MODE_AUTO: begin
        tgt = effective_target();
        if (p >= tgt) begin
          fill_on   = 1'b0;
          drive_one = 1'b0;
          drive_two = 1'b0;
        end else if (!fill_on && p >= start_reg) begin
          // Inside the hysteresis band with no fill running.
          drive_one = 1'b0;
          drive_two = 1'b0;
        end else begin
          fill_on = 1'b1;
          if (p <= both_reg) begin
            drive_one = 1'b1;
            drive_two = 1'b1;
          end else begin
            since_toggle = clock_ms - last_toggle_ms;
            if (since_toggle >= {10'd0, ival_reg}) begin
              alt_sel        = ~alt_sel;
              last_toggle_ms = clock_ms;
            end
            drive_one = ~alt_sel;
            drive_two = alt_sel;
          end
        end
      end
      MODE_OFF: begin
        drive_one = 1'b0;
        drive_two = 1'b0;
      end
      MODE_BOTH: begin
        drive_one = 1'b1;
        drive_two = 1'b1;
      end
      MODE_ONE_ONLY: begin
        drive_one = 1'b1;
        drive_two = 1'b0;
      end
      MODE_TWO_ONLY: begin
        drive_one = 1'b0;
        drive_two = 1'b1;
      end
      default: begin
      end
    endcase
    st.pump_one = drive_one;
    st.pump_two = drive_two;
    st.fill     = fill_on;
    st.run_one  = run_one_ms;
    st.run_two  = run_two_ms;
    return st;
  endfunction

  function automatic void flag_error(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORT)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  // Result side: random back-pressure and the field checks.
  always @(posedge clk) begin
    pump_status_t want;
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        flag_error("result beat with nothing pending", 0, 1);
      end else begin
        want = pending_status.pop_front();
        if (out_tdata[OUT_P1_BIT] !== want.pump_one)
          flag_error("pump_one_on", 32'(want.pump_one), 32'(out_tdata[OUT_P1_BIT]));
        if (out_tdata[OUT_P2_BIT] !== want.pump_two)
          flag_error("pump_two_on", 32'(want.pump_two), 32'(out_tdata[OUT_P2_BIT]));
        if (out_tdata[OUT_FILL_BIT] !== want.fill)
          flag_error("fill_active", 32'(want.fill), 32'(out_tdata[OUT_FILL_BIT]));
        if (out_tdata[34:3] !== want.run_one)
          flag_error("runtime_one_ms", want.run_one, out_tdata[34:3]);
        if (out_tdata[66:35] !== want.run_two)
          flag_error("runtime_two_ms", want.run_two, out_tdata[66:35]);
      end
    end
  end

  task automatic send_tick(input logic [11:0] p, input logic [15:0] el,
                           input logic clr_one, input logic clr_two);
    logic [IN_W-1:0] beat;
    beat        = '0;
    beat[11:0]  = p;
    beat[27:12] = el;
    beat[28]    = clr_one;
    beat[29]    = clr_two;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    do @(posedge clk); while (!in_tready);
    pending_status.push_back(advance_pumps(p, el, clr_one, clr_two));
  endtask

  // Stop sending and let every pending result come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [2:0] mode, input logic [11:0] tgt,
                               input logic [11:0] start, input logic [11:0] mx,
                               input logic [11:0] both, input logic [21:0] ival);
    drain_results();
    put_reg(REG_PUMP_MODE, {19'd0, mode});
    put_reg(REG_TARGET, {10'd0, tgt});
    put_reg(REG_FILL_START, {10'd0, start});
    put_reg(REG_MAX, {10'd0, mx});
    put_reg(REG_BOTH_PUMPS, {10'd0, both});
    put_reg(REG_SWITCH_IVAL, ival);
    cfg_we     <= 1'b0;
    mode_reg   = mode;
    target_reg = tgt;
    start_reg  = start;
    max_reg    = mx;
    both_reg   = both;
    ival_reg   = ival;
  endtask

  // Default settings: hysteresis band edges, both-pump threshold, alternation
  // after the interval, runtime clears and the largest elapsed step.
  task automatic test_default_fill();
    send_tick(12'd1300, 16'd0, 1'b0, 1'b0);
    send_tick(12'd1200, 16'd100, 1'b0, 1'b0);
    send_tick(12'd1199, 16'd100, 1'b0, 1'b0);
    send_tick(12'd1000, 16'd65535, 1'b0, 1'b0);
    send_tick(12'd1499, 16'd65535, 1'b1, 1'b0);
    send_tick(12'd1500, 16'd1, 1'b0, 1'b0);
    send_tick(12'd1350, 16'd10, 1'b0, 1'b0);
    send_tick(12'd4095, 16'd65535, 1'b1, 1'b1);
    send_tick(12'd0, 16'd65535, 1'b0, 1'b1);
  endtask

  // Manual modes, entered with a fill running; undefined codes hold drives.
  task automatic test_manual_modes();
    load_settings(MODE_BOTH, RST_TARGET, RST_FILL_START, RST_MAX, RST_BOTH_PUMPS,
                  RST_SWITCH_IVAL);
    send_tick(12'd0, 16'd1000, 1'b0, 1'b0);
    load_settings(MODE_ONE_ONLY, RST_TARGET, RST_FILL_START, RST_MAX, RST_BOTH_PUMPS,
                  RST_SWITCH_IVAL);
    send_tick(12'd4095, 16'd65535, 1'b0, 1'b0);
    load_settings(MODE_TWO_ONLY, RST_TARGET, RST_FILL_START, RST_MAX, RST_BOTH_PUMPS,
                  RST_SWITCH_IVAL);
    send_tick(12'd2048, 16'd65535, 1'b1, 1'b0);
    load_settings(MODE_UNDEF_LO, RST_TARGET, RST_FILL_START, RST_MAX, RST_BOTH_PUMPS,
                  RST_SWITCH_IVAL);
    send_tick(12'd0, 16'd3000, 1'b0, 1'b0);
    load_settings(MODE_UNDEF_HI, RST_TARGET, RST_FILL_START, RST_MAX, RST_BOTH_PUMPS,
                  RST_SWITCH_IVAL);
    send_tick(12'd4095, 16'd7, 1'b0, 1'b1);
    load_settings(MODE_OFF, RST_TARGET, RST_FILL_START, RST_MAX, RST_BOTH_PUMPS,
                  RST_SWITCH_IVAL);
    send_tick(12'd0, 16'd65535, 1'b0, 1'b0);
  endtask

  // Target clamping at the register extremes, zero and longest interval.
  task automatic test_target_clamp();
    // Fill start above the maximum wins; a zero interval toggles on every alternating tick.
    load_settings(MODE_AUTO, 12'd4095, 12'd2000, 12'd0, 12'd0, 22'd0);
    send_tick(12'd1999, 16'd5, 1'b0, 1'b0);
    send_tick(12'd1, 16'd5, 1'b0, 1'b0);
    send_tick(12'd0, 16'd5, 1'b0, 1'b0);
    send_tick(12'd2000, 16'd5, 1'b0, 1'b0);
    load_settings(MODE_AUTO, 12'd0, 12'd0, 12'd4095, 12'd4095, IVAL_MAX);
    send_tick(12'd0, 16'd65535, 1'b0, 1'b0);
    load_settings(MODE_AUTO, 12'd4095, 12'd4095, 12'd4095, 12'd4095, IVAL_MAX);
    send_tick(12'd4094, 16'd65535, 1'b0, 1'b0);
    send_tick(12'd4095, 16'd65535, 1'b0, 1'b0);
  endtask

  task automatic pick_settings();
    logic [2:0]  mode;
    logic [21:0] ival;
    int          both, start, tgt, mx;
    mode = ($urandom_range(0, 99) < 70) ? MODE_AUTO : 3'($urandom_range(1, 7));
    if ($urandom_range(0, 4) != 0) begin
      both  = $urandom_range(0, 3000);
      start = both + $urandom_range(0, 600);
      tgt   = start + $urandom_range(0, 600);
      mx    = ($urandom_range(0, 3) == 0) ? tgt - $urandom_range(0, 300)
                                          : tgt + $urandom_range(0, 200);
      if (start > 4095) start = 4095;
      if (tgt > 4095) tgt = 4095;
      if (mx > 4095) mx = 4095;
      if (mx < 0) mx = 0;
    end else begin
      both  = $urandom_range(0, 4095);
      start = $urandom_range(0, 4095);
      tgt   = $urandom_range(0, 4095);
      mx    = $urandom_range(0, 4095);
    end
    case ($urandom_range(0, 4))
      0:       ival = 22'd0;
      1:       ival = IVAL_MAX;
      2:       ival = 22'($urandom_range(0, 3600000));
      default: ival = 22'($urandom_range(0, 150000));
    endcase
    load_settings(mode, 12'(tgt), 12'(start), 12'(mx), 12'(both), ival);
  endtask

  // Pressure sweeps up and down across the thresholds so that fill cycles
  // start, alternate and stop; a tenth of the samples jump anywhere.
  task automatic test_random_fill_cycles();
    int       lo, hi, step_max, walk_p;
    bit       rising;
    logic [15:0] el;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      pick_settings();
      lo = (both_reg > 40) ? int'(both_reg) - 40 : 0;
      hi = int'(effective_target()) + 40;
      if (hi > 4095) hi = 4095;
      if (hi <= lo + 8) lo = (hi > 200) ? hi - 200 : 0;
      step_max = (hi - lo) / 6 + 4;
      walk_p = $urandom_range(lo, hi);
      rising = 1'($urandom_range(0, 1));
      for (int n = 0; n < SEG_TICKS; n++) begin
        if (rising) begin
          walk_p += $urandom_range(0, step_max);
          if (walk_p >= hi) rising = 1'b0;
        end else begin
          walk_p -= $urandom_range(0, step_max);
          if (walk_p <= lo) rising = 1'b1;
        end
        if (walk_p < 0) walk_p = 0;
        if (walk_p > 4095) walk_p = 4095;
        case ($urandom_range(0, 9))
          0:       el = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          1, 2, 3: el = 16'($urandom_range(0, 65535));
          default: el = 16'($urandom_range(0, 2000));
        endcase
        if ($urandom_range(0, 199) == 0) drain_results();
        send_tick(($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095)) : 12'(walk_p),
                  el, ($urandom_range(0, 99) < 3), ($urandom_range(0, 99) < 3));
      end
    end
  endtask

  initial begin
    fill_on        = 1'b0;
    alt_sel        = 1'b0;
    drive_one      = 1'b0;
    drive_two      = 1'b0;
    clock_ms       = '0;
    last_toggle_ms = '0;
    run_one_ms     = '0;
    run_two_ms     = '0;
    mode_reg       = MODE_AUTO;
    target_reg     = RST_TARGET;
    start_reg      = RST_FILL_START;
    max_reg        = RST_MAX;
    both_reg       = RST_BOTH_PUMPS;
    ival_reg       = RST_SWITCH_IVAL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 32;
    rx_idle_pct = 80;
    test_default_fill();
    test_manual_modes();
    test_target_clamp();
    test_random_fill_cycles();

    tx_idle_pct = 80;
    rx_idle_pct = 32;
    test_random_fill_cycles();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_fill_cycles();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dphc_pkg.sv
rtl/dual_pump_hysteresis_controller.sv
rtl/dphc_checker.sv
sim/dual_pump_hysteresis_controller_test.sv
